// File: sv/wmma_pkg.sv
// Shared widths and constants for the window min/max/average block.
`default_nettype none

package wmma_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned STAT_W           = 31;
  localparam int unsigned COUNT_OUT_W      = 7;
  localparam int unsigned COUNT_OUT_MAX    = 127;
  localparam int unsigned WINDOW_DEPTH_DEF = 64;
  localparam int unsigned DIV_STEPS        = 32;

endpackage

`default_nettype wire

// File: sv/wmma_in_if.sv
// Input channel interface: frame index and timing sample word.
`default_nettype none

interface wmma_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [wmma_pkg::DATA_W-1:0]       frame_index;
  logic signed [wmma_pkg::DATA_W-1:0]       sample_value;

  modport source (output valid, output frame_index, output sample_value, input ready);
  modport sink   (input valid, input frame_index, input sample_value, output ready);
endinterface

`default_nettype wire

// File: sv/wmma_out_if.sv
// Result channel interface: latest sample and window statistics word.
`default_nettype none

interface wmma_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [wmma_pkg::DATA_W-1:0]       latest_value;
  logic        [wmma_pkg::COUNT_OUT_W-1:0]  valid_count;
  logic        [wmma_pkg::STAT_W-1:0]       window_minimum;
  logic        [wmma_pkg::STAT_W-1:0]       window_maximum;
  logic        [wmma_pkg::STAT_W-1:0]       window_average;

  modport source (output valid, output latest_value, output valid_count,
                  output window_minimum, output window_maximum,
                  output window_average, input ready);
  modport sink   (input valid, input latest_value, input valid_count,
                  input window_minimum, input window_maximum,
                  input window_average, output ready);
endinterface

`default_nettype wire

// File: sv/wmma_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module wmma_ram #(
  parameter int unsigned WIDTH = wmma_pkg::DATA_W,
  parameter int unsigned DEPTH = wmma_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/wmma_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, used for the window mean.
`default_nettype none

module wmma_div #(
  parameter int unsigned DIVISOR_W = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [DIVISOR_W-1:0]          rem_init,
  input  wire logic [wmma_pkg::DATA_W-1:0]   dividend,
  input  wire logic [DIVISOR_W-1:0]          divisor,
  output logic                               done,
  output logic      [wmma_pkg::DATA_W-1:0]   quotient
);

  localparam int unsigned STEP_W = $clog2(wmma_pkg::DIV_STEPS);

  logic                          busy_r;
  logic                          done_r;
  logic [STEP_W-1:0]             step_r;
  logic [DIVISOR_W-1:0]          rem_r;
  logic [DIVISOR_W-1:0]          div_r;
  logic [wmma_pkg::DATA_W-1:0]   quo_r;

  logic [DIVISOR_W:0]            shifted;
  logic [DIVISOR_W:0]            diff;
  logic                          fits;

  // The partial remainder stays below the divisor, so one extra bit holds the shift.
  assign shifted = {rem_r, quo_r[wmma_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign fits    = shifted >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= rem_init;
        div_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r  <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_r  <= {quo_r[wmma_pkg::DATA_W-2:0], fits};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(wmma_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule

`default_nettype wire

// File: sv/window_min_max_average.sv
// Top level: sliding-window minimum, maximum and mean over timing samples.
`default_nettype none

// Each input word writes its sample into a WINDOW_DEPTH-entry window at slot
// frame_index mod WINDOW_DEPTH, then the whole window is scanned and every entry
// above zero counts toward the minimum, maximum and truncated mean. After reset
// the window RAM is zeroed one entry per cycle, and the input stays not ready until
// every entry is cleared. No new word is accepted until the last one's result is
// in the output register. The slot comes from a constant reciprocal multiply and
// is then written, the scan reads one window entry per cycle through the RAM's
// single read port, and the serial divider forms the mean, a step skipped when no
// entry is above zero. A finished result waits in the output register while the
// next word is accepted; the block stalls only when that register is still full
// as the next result is ready.
module window_min_max_average #(
  parameter int unsigned WINDOW_DEPTH = wmma_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wmma_in_if.sink    in_chan,
  wmma_out_if.source out_chan
);

  localparam int unsigned DW     = wmma_pkg::DATA_W;
  localparam int unsigned SW     = wmma_pkg::STAT_W;
  localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = SW + CNT_W;
  localparam int unsigned SAT_W  = (CNT_W > wmma_pkg::COUNT_OUT_W) ? CNT_W
                                                                    : wmma_pkg::COUNT_OUT_W;
  // Rounded-up reciprocal of the depth: (frame * RECIP) >> SHIFT is the exact
  // quotient for every 32-bit frame index.
  localparam int unsigned RECIP_W    = DW + 1;
  localparam int unsigned SHIFT      = DW + ADDR_W;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1)
                                       / 64'(WINDOW_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_WRITE,
    ST_SCAN,
    ST_DIV_GO,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   rd_vld_r;
  logic                   rd_last_r;
  logic [ADDR_W-1:0]      frame_lo_r;
  logic [ADDR_W-1:0]      mod_quo_r;
  logic [ADDR_W-1:0]      slot_r;
  logic [DW-1:0]          sample_r;
  logic [CNT_W-1:0]       acc_cnt_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SW-1:0]          min_r;
  logic [SW-1:0]          max_r;
  logic [SW-1:0]          mean_r;

  logic                   out_valid_r;
  logic [DW-1:0]          out_latest_r;
  logic [wmma_pkg::COUNT_OUT_W-1:0] out_count_r;
  logic [SW-1:0]          out_min_r;
  logic [SW-1:0]          out_max_r;
  logic [SW-1:0]          out_avg_r;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [DW-1:0]          ram_wdata;
  logic [DW-1:0]          ram_rdata;

  logic                   div_start;
  logic [CNT_W-1:0]       div_rem_init;
  logic [DW-1:0]          div_dividend;
  logic [CNT_W-1:0]       div_divisor;
  logic                   div_done;
  logic [DW-1:0]          div_quo;

  logic                   in_acc;
  logic                   out_load;
  logic [DW+RECIP_W-1:0]  mod_prod;
  logic [ADDR_W-1:0]      slot_calc;
  logic                   entry_pos;
  logic [SW-1:0]          entry_val;
  logic [SAT_W-1:0]       count_ext;
  logic [wmma_pkg::COUNT_OUT_W-1:0] count_sat;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && (state_r == ST_IDLE);
  assign out_load      = (state_r == ST_HOLD) && (!out_valid_r || out_chan.ready);

  // Only the low quotient bits matter, since the remainder fits in the slot width.
  assign mod_prod  = (DW+RECIP_W)'(in_chan.frame_index) * (DW+RECIP_W)'(RECIP);
  assign slot_calc = frame_lo_r - mod_quo_r * ADDR_W'(WINDOW_DEPTH);

  assign entry_pos = !ram_rdata[DW-1] && (ram_rdata[SW-1:0] != '0);
  assign entry_val = ram_rdata[SW-1:0];

  assign count_ext = SAT_W'(acc_cnt_r);
  assign count_sat = (count_ext > SAT_W'(wmma_pkg::COUNT_OUT_MAX))
                   ? wmma_pkg::COUNT_OUT_W'(wmma_pkg::COUNT_OUT_MAX)
                   : count_ext[wmma_pkg::COUNT_OUT_W-1:0];

  always_comb begin
    ram_we    = (state_r == ST_CLEAR) || (state_r == ST_WRITE);
    ram_waddr = (state_r == ST_CLEAR) ? cnt_r[ADDR_W-1:0] : slot_r;
    ram_wdata = (state_r == ST_CLEAR) ? '0 : sample_r;
  end

  // The sum's high part is already below the count, so 32 steps suffice for the mean.
  always_comb begin
    div_start    = (state_r == ST_DIV_GO) && (acc_cnt_r != '0);
    div_rem_init = {1'b0, sum_r[SUM_W-1:DW]};
    div_dividend = sum_r[DW-1:0];
    div_divisor  = acc_cnt_r;
  end

  wmma_ram #(
    .WIDTH (DW),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  wmma_div #(
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .rem_init  (div_rem_init),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          if (cnt_r == CNT_W'(WINDOW_DEPTH - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            sample_r   <= in_chan.sample_value;
            frame_lo_r <= in_chan.frame_index[ADDR_W-1:0];
            mod_quo_r  <= mod_prod[SHIFT +: ADDR_W];
            state_r    <= ST_MOD;
          end
        end
        ST_MOD: begin
          slot_r  <= slot_calc;
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          cnt_r     <= '0;
          acc_cnt_r <= '0;
          sum_r     <= '0;
          min_r     <= '0;
          max_r     <= '0;
          state_r   <= ST_SCAN;
        end
        ST_SCAN: begin
          // Reads are issued one per cycle; the registered read data returns in the following cycle.
          if (cnt_r != CNT_W'(WINDOW_DEPTH)) begin
            cnt_r     <= cnt_r + 1'b1;
            rd_vld_r  <= 1'b1;
            rd_last_r <= (cnt_r == CNT_W'(WINDOW_DEPTH - 1));
          end else begin
            rd_vld_r  <= 1'b0;
            rd_last_r <= 1'b0;
          end
          if (rd_vld_r && entry_pos) begin
            acc_cnt_r <= acc_cnt_r + 1'b1;
            sum_r     <= sum_r + SUM_W'(entry_val);
            if ((acc_cnt_r == '0) || (entry_val < min_r)) begin
              min_r <= entry_val;
            end
            if (entry_val > max_r) begin
              max_r <= entry_val;
            end
          end
          if (rd_vld_r && rd_last_r) begin
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          if (acc_cnt_r == '0) begin
            mean_r  <= '0;
            state_r <= ST_HOLD;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mean_r  <= div_quo[SW-1:0];
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            out_latest_r <= sample_r;
            out_count_r  <= count_sat;
            out_min_r    <= (acc_cnt_r == '0) ? '0 : min_r;
            out_max_r    <= max_r;
            out_avg_r    <= mean_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.latest_value   = out_latest_r;
  assign out_chan.valid_count    = out_count_r;
  assign out_chan.window_minimum = out_min_r;
  assign out_chan.window_maximum = out_max_r;
  assign out_chan.window_average = out_avg_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_cnt_r <= CNT_W'(WINDOW_DEPTH))
    else $error("positive entry count exceeds window depth");

  a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_GO && acc_cnt_r != '0) |-> (min_r <= max_r))
    else $error("window minimum above maximum");

  a_mean_between: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && acc_cnt_r != '0) |-> (mean_r >= min_r && mean_r <= max_r))
    else $error("window mean outside minimum and maximum");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the division state");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the sliding-window minimum, maximum and mean block.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DATA_W        = wmma_pkg::DATA_W;
  localparam int unsigned STAT_W        = wmma_pkg::STAT_W;
  localparam int unsigned COUNT_OUT_W   = wmma_pkg::COUNT_OUT_W;
  localparam int unsigned COUNT_OUT_MAX = wmma_pkg::COUNT_OUT_MAX;
  localparam int unsigned WINDOW_DEPTH  = wmma_pkg::WINDOW_DEPTH_DEF;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned RANDOM_WORDS  = 560;
  localparam int unsigned STEADY_WORDS  = 40;
  localparam int unsigned SQUEEZE_WORDS = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] latest;
    logic [COUNT_OUT_W-1:0]   count;
    logic [STAT_W-1:0]        minimum;
    logic [STAT_W-1:0]        maximum;
    logic [STAT_W-1:0]        average;
  } window_stats_t;

  logic clk;
  logic rst_n;

  wmma_in_if  in_chan ();
  wmma_out_if out_chan ();

  window_min_max_average #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic signed [DATA_W-1:0] shadow_window [WINDOW_DEPTH];
  window_stats_t            pending_stats [$];
  int unsigned              error_count  = 0;
  int unsigned              results_seen = 0;
  int unsigned              sink_wait;
  bit                       pace_on = 1'b1;
  logic                     holding;
  logic [DATA_W-1:0]        frame_counter;
  event                     hold_off_start;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stores the sample in the shadow window and returns the statistics the
  // block must report for it.
  function automatic window_stats_t window_stats(input logic [DATA_W-1:0] frame,
                                                 input logic [DATA_W-1:0] sample);
    window_stats_t     s;
    logic [63:0]       total;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] v;
    logic [63:0]       mean;
    int unsigned       n;
    shadow_window[frame % WINDOW_DEPTH] = sample;
    total = '0;
    lo    = '0;
    hi    = '0;
    n     = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (shadow_window[i] > 0) begin
        v = shadow_window[i];
        if (n == 0 || v < lo) lo = v;
        if (v > hi) hi = v;
        total += v;
        n++;
      end
    end
    mean      = (n != 0) ? total / n : 64'd0;
    s.latest  = sample;
    s.count   = (n > COUNT_OUT_MAX) ? COUNT_OUT_W'(COUNT_OUT_MAX) : n[COUNT_OUT_W-1:0];
    s.minimum = lo[STAT_W-1:0];
    s.maximum = hi[STAT_W-1:0];
    s.average = mean[STAT_W-1:0];
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] draw_sample();
    logic [DATA_W-1:0] r;
    case ($urandom_range(0, 9))
      0:       r = '0;
      1:       r = $urandom | 32'h8000_0000;
      2:       r = $urandom;
      3:       r = 32'h7FFF_FFFF - $urandom_range(0, 255);
      default: r = $urandom >> $urandom_range(1, 31);
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] draw_frame();
    if ($urandom_range(0, 9) == 0) frame_counter = $urandom;
    else frame_counter = frame_counter + 1;
    return frame_counter;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("%0t: result %0d, %s: got %0d, expected %0d",
             $time, results_seen, what, got, want);
  endtask

  // Idle cycles are counted only while the block is ready, so that they
  // actually delay the word.
  task automatic send_word(input logic [DATA_W-1:0] frame, input logic [DATA_W-1:0] sample);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) in_chan.valid <= 1'b0;
    while (gap != 0) begin
      @(posedge clk);
      if (in_chan.ready) gap--;
    end
    in_chan.valid        <= 1'b1;
    in_chan.frame_index  <= frame;
    in_chan.sample_value <= sample;
    do @(posedge clk); while (!in_chan.ready);
    pending_stats.insert(pending_stats.size(), window_stats(frame, sample));
  endtask

  task automatic stop_words();
    in_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: when pacing is on, after about half of the accepted results ready
  // stays low for a drawn number of cycles in which a result is on offer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      sink_wait      <= 0;
    end else if (holding) begin
      out_chan.ready <= 1'b0;
    end else if (out_chan.valid && out_chan.ready) begin
      if (pace_on && $urandom_range(0, 1) == 1) begin
        sink_wait      <= $urandom_range(1, 5);
        out_chan.ready <= 1'b0;
      end else begin
        sink_wait      <= 0;
        out_chan.ready <= 1'b1;
      end
    end else if (sink_wait != 0) begin
      if (out_chan.valid) begin
        sink_wait      <= sink_wait - 1;
        out_chan.ready <= (sink_wait == 1);
      end
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  initial begin
    holding <= 1'b0;
    forever begin
      @(hold_off_start);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  always @(posedge clk) begin
    window_stats_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_stats.size() == 0) begin
        report_mismatch("unexpected word, latest_value", out_chan.latest_value, 0);
      end else begin
        want = pending_stats.pop_front();
        if (out_chan.latest_value !== want.latest)
          report_mismatch("latest_value", out_chan.latest_value, want.latest);
        if (out_chan.valid_count !== want.count)
          report_mismatch("valid_count", out_chan.valid_count, want.count);
        if (out_chan.window_minimum !== want.minimum)
          report_mismatch("window_minimum", out_chan.window_minimum, want.minimum);
        if (out_chan.window_maximum !== want.maximum)
          report_mismatch("window_maximum", out_chan.window_maximum, want.maximum);
        if (out_chan.window_average !== want.average)
          report_mismatch("window_average", out_chan.window_average, want.average);
      end
    end
  end

  // Zero, minus one and the most negative value all leave the window empty.
  task automatic test_empty_window();
    send_word(32'd0, 32'h0000_0000);
    send_word(32'd1, 32'hFFFF_FFFF);
    send_word(32'd2, 32'h8000_0000);
    stop_words();
  endtask

  task automatic test_field_extremes();
    send_word(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'd64,        32'h0000_0001);
    send_word(32'h8000_0001, 32'h0001_0000);
    send_word(32'd3,         32'h7FFF_FFFE);
    // A negative sample over a positive entry drops it from the statistics.
    send_word(32'hFFFF_FFFF, 32'hFFFF_0000);
    send_word(32'h7FFF_FFC0, 32'h0001_8000);
    stop_words();
  endtask

  task automatic test_truncated_mean();
    send_word(32'd5,         32'h0000_0002);
    send_word(32'd6,         32'h0000_0003);
    send_word(32'h5555_5555, 32'h2AAA_AAAA);
    send_word(32'hAAAA_AAAA, 32'h5555_5555);
    stop_words();
  endtask

  // Overwrites every positive entry left by the tests above, so the last
  // result falls back to an empty window.
  task automatic test_clear_to_empty();
    send_word(32'd128,       32'h0000_0000);
    send_word(32'd65,        32'h8000_0000);
    send_word(32'd195,       32'h0000_0000);
    send_word(32'd69,        32'hFFFF_FFFF);
    send_word(32'h0001_0006, 32'h0000_0000);
    send_word(32'd85,        32'hC000_0000);
    send_word(32'd106,       32'h0000_0000);
    stop_words();
  endtask

  task automatic test_random_traffic();
    frame_counter = $urandom;
    repeat (RANDOM_WORDS) send_word(draw_frame(), draw_sample());
    stop_words();
  endtask

  // The result side holds off while words keep coming, so the block fills up
  // and has to stall its input.
  task automatic test_output_hold_off();
    -> hold_off_start;
    repeat (SQUEEZE_WORDS) send_word(draw_frame(), draw_sample());
    stop_words();
  endtask

  task automatic test_back_to_back();
    pace_on = 1'b0;
    repeat (STEADY_WORDS) send_word(draw_frame(), draw_sample());
    stop_words();
    pace_on = 1'b1;
  endtask

  initial begin
    in_chan.valid        <= 1'b0;
    in_chan.frame_index  <= '0;
    in_chan.sample_value <= '0;
    rst_n                <= 1'b0;
    foreach (shadow_window[i]) shadow_window[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_window();
    test_field_extremes();
    test_truncated_mean();
    test_clear_to_empty();
    test_random_traffic();
    test_output_hold_off();
    test_back_to_back();

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (WINDOW_DEPTH + 80) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
